// ===== rtl/compacting_array_table_top_assert.svh =====
// Assertion macros shared by the compacting array table RTL
`ifndef COMPACTING_ARRAY_TABLE_TOP_ASSERT_SVH
`define COMPACTING_ARRAY_TABLE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CAT_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("compacting array table check failed");

// antecedent implies consequent in the next cycle
`define CAT_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("compacting array table check failed");

`endif

// ===== rtl/cat_pkg.sv =====
// Shared constants and field widths for the compacting array table
package cat_pkg;

  localparam int DEFAULT_MAX_ENTRIES = 64;

  localparam int OP_W    = 2;
  localparam int VAL_W   = 32;
  localparam int IDX_W   = 6;
  localparam int ST_W    = 2;
  localparam int CNT_W   = 7;
  localparam int CAP_W   = 8;
  localparam int CFG_W   = 7;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd3;

  localparam logic [CAP_W-1:0] CAP_LIMIT = 8'hFF;

endpackage

// ===== rtl/cat_if.sv =====
// Channel interfaces: operation requests, results and the configuration write
interface cat_req_if;
  logic                               valid;
  logic                               ready;
  logic [cat_pkg::OP_W-1:0]           op;
  logic signed [cat_pkg::VAL_W-1:0]   value;
  logic [cat_pkg::IDX_W-1:0]          index;

  modport source (output valid, op, value, index, input ready);
  modport sink   (input valid, op, value, index, output ready);
endinterface

interface cat_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [cat_pkg::ST_W-1:0]           status;
  logic signed [cat_pkg::VAL_W-1:0]   read_value;
  logic [cat_pkg::IDX_W-1:0]          found_index;
  logic [cat_pkg::CNT_W-1:0]          entry_count;
  logic [cat_pkg::CAP_W-1:0]          nominal_capacity;

  modport source (output valid, status, read_value, found_index, entry_count,
                  nominal_capacity, input ready);
  modport sink   (input valid, status, read_value, found_index, entry_count,
                  nominal_capacity, output ready);
endinterface

interface cat_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cat_pkg::CFG_W-1:0]          initial_capacity;

  modport source (output valid, initial_capacity, input ready);
  modport sink   (input valid, initial_capacity, output ready);
endinterface

// ===== rtl/cat_mem.sv =====
// Entry store: one write port, one read port with registered read data
module cat_mem #(
  parameter int  MAX_ENTRIES = cat_pkg::DEFAULT_MAX_ENTRIES,
  localparam int AW = $clog2(MAX_ENTRIES)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [cat_pkg::VAL_W-1:0]     wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [cat_pkg::VAL_W-1:0]     rdata
);
  import cat_pkg::*;

  logic [VAL_W-1:0] mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cat_ctrl.sv =====
// Sequencer: decodes an operation, walks the store one entry a cycle, builds the result
`include "compacting_array_table_top_assert.svh"

module cat_ctrl #(
  parameter int  MAX_ENTRIES = cat_pkg::DEFAULT_MAX_ENTRIES,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  cat_req_if.sink                    req,
  cat_rsp_if.source                  rsp,
  cat_cfg_if.sink                    cfg,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [cat_pkg::VAL_W-1:0]  mem_wdata,
  output logic [AW-1:0]              mem_raddr,
  input  logic [cat_pkg::VAL_W-1:0]  mem_rdata
);
  import cat_pkg::*;

  localparam int IW = (CW > IDX_W) ? CW : IDX_W;
  localparam int KW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_FIND  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state, state_next;
  logic [OP_W-1:0]   op_r;
  logic [VAL_W-1:0]  value_r;
  logic [IDX_W-1:0]  index_r;
  logic [CW-1:0]     count, count_next;
  logic [CAP_W-1:0]  cap, cap_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic [ST_W-1:0]   status_r, status_next;
  logic [VAL_W-1:0]  rd_r, rd_next;
  logic [CW-1:0]     fi_r, fi_next;
  logic              out_valid, out_valid_next;
  logic              load_out;

  logic [CW-1:0]     idx_c;
  logic [CW-1:0]     idx_inc;
  logic [CW-1:0]     ptr_inc;
  logic [CW-1:0]     ptr_inc2;
  logic [CW-1:0]     count_dec;
  logic              range_err;
  logic              full;
  logic              cap_eq;
  logic              cap_halve;
  logic              hit;
  logic [CW+CNT_W-1:0] count_wide;
  logic [CW+IDX_W-1:0] fi_wide;

  assign idx_c     = CW'(index_r);
  assign idx_inc   = idx_c + CW'(1);
  assign ptr_inc   = ptr + CW'(1);
  assign ptr_inc2  = ptr_inc + CW'(1);
  assign count_dec = count - CW'(1);
  assign range_err = IW'(index_r) >= IW'(count);
  assign full      = count == CW'(MAX_ENTRIES);
  assign cap_eq    = KW'(cap) == KW'(count);
  assign cap_halve = KW'(cap >> 1) > KW'(count_dec);
  // the one shared compare: every find step and nothing else
  assign hit       = mem_rdata == value_r;

  assign req.ready = state == S_IDLE;
  assign cfg.ready = state == S_IDLE;
  assign load_out  = (state == S_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    state_next  = state;
    count_next  = count;
    cap_next    = cap;
    ptr_next    = ptr;
    status_next = status_r;
    rd_next     = rd_r;
    fi_next     = fi_r;
    mem_we      = 1'b0;
    mem_waddr   = ptr[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = ptr_inc[AW-1:0];

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          status_next = ST_OK;
          rd_next     = '0;
          fi_next     = '0;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_APPEND: begin
            if (full) begin
              status_next = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = count[AW-1:0];
              mem_wdata  = value_r;
              count_next = count + CW'(1);
              if (cap_eq) begin
                cap_next = cap[CAP_W-1] ? CAP_LIMIT : {cap[CAP_W-2:0], 1'b0};
              end
            end
            state_next = S_DONE;
          end
          OP_REMOVE: begin
            if (range_err) begin
              status_next = ST_RANGE;
              state_next  = S_DONE;
            end else begin
              ptr_next   = idx_c;
              mem_raddr  = idx_inc[AW-1:0];
              state_next = S_SHIFT;
            end
          end
          OP_READ: begin
            if (range_err) begin
              status_next = ST_RANGE;
              state_next  = S_DONE;
            end else begin
              mem_raddr  = idx_c[AW-1:0];
              state_next = S_READ;
            end
          end
          default: begin
            ptr_next  = '0;
            mem_raddr = '0;
            if (count == '0) begin
              status_next = ST_ABSENT;
              state_next  = S_DONE;
            end else begin
              state_next = S_FIND;
            end
          end
        endcase
      end
      S_READ: begin
        rd_next    = mem_rdata;
        state_next = S_DONE;
      end
      S_SHIFT: begin
        // rdata holds entry ptr+1; move it down and fetch the next one
        if (ptr_inc < count) begin
          mem_we    = 1'b1;
          mem_waddr = ptr[AW-1:0];
          mem_wdata = mem_rdata;
          mem_raddr = ptr_inc2[AW-1:0];
          ptr_next  = ptr_inc;
        end else begin
          count_next = count_dec;
          if (cap_halve) begin
            cap_next = cap >> 1;
          end
          state_next = S_DONE;
        end
      end
      S_FIND: begin
        if (hit) begin
          fi_next    = ptr;
          state_next = S_DONE;
        end else if (ptr_inc >= count) begin
          status_next = ST_ABSENT;
          state_next  = S_DONE;
        end else begin
          ptr_next  = ptr_inc;
          mem_raddr = ptr_inc[AW-1:0];
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // register write empties the list; only taken while idle
    if (cfg.valid && cfg.ready) begin
      count_next = '0;
      cap_next   = (cfg.initial_capacity == '0) ? CAP_W'(1)
                                                : CAP_W'(cfg.initial_capacity);
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap       <= CAP_W'(1);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cap       <= cap_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_r    <= req.op;
      value_r <= req.value;
      index_r <= req.index;
    end
    ptr      <= ptr_next;
    status_r <= status_next;
    rd_r     <= rd_next;
    fi_r     <= fi_next;
  end

  assign count_wide = (CW + CNT_W)'(count);
  assign fi_wide    = (CW + IDX_W)'(fi_r);

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status           <= status_r;
      rsp.read_value       <= rd_r;
      rsp.found_index      <= fi_wide[IDX_W-1:0];
      rsp.entry_count      <= count_wide[CNT_W-1:0];
      rsp.nominal_capacity <= cap;
    end
  end

  assign rsp.valid = out_valid;

  `CAT_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(MAX_ENTRIES))
  `CAT_ASSERT_IMP(a_cap_nonzero, clk, rst, 1'b1, cap != '0)
  `CAT_ASSERT_NXT(a_accept_exec, clk, rst, req.valid && req.ready, state == S_EXEC)
  `CAT_ASSERT_IMP(a_scan_ptr, clk, rst, state == S_SHIFT || state == S_FIND, ptr < count)
  `CAT_ASSERT_NXT(a_result_out, clk, rst, load_out, out_valid)

endmodule

// ===== rtl/compacting_array_table_top.sv =====
// Top level of the compacting array table: sequencer plus entry store
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    op, value, index
//   rsp      out  valid / ready    status, read_value, found_index,
//                                  entry_count, nominal_capacity
//   cfg      in   valid / ready    initial_capacity (ready only while idle)
//
// One op in flight. Append and out-of-range ops run EXEC then DONE; read adds READ.
// Remove walks SHIFT from the index to the end, find walks FIND to a match or the end:
// the single store read port yields one entry per cycle. req.ready is high only idle.
// Synchronous reset empties the list and sets capacity to one; no clearing pass.
// A stalled result holds in the output register and the next op may transfer meanwhile.
module compacting_array_table_top #(
  parameter int MAX_ENTRIES = cat_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  cat_req_if.sink     req,
  cat_rsp_if.source   rsp,
  cat_cfg_if.sink     cfg
);
  import cat_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  cat_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cat_mem #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== tb/sv/compacting_array_table_top_tb.sv =====
// Self-checking testbench for the compacting array table: directed and random ops
`timescale 1ns / 1ps

module compacting_array_table_top_tb;
  import cat_pkg::*;

  localparam int TABLE_DEPTH   = DEFAULT_MAX_ENTRIES;
  localparam int MAX_WAIT      = 17;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 40;
  localparam int PRINT_LIMIT   = 50;

  typedef struct {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
    logic [IDX_W-1:0]        found_index;
    logic [CNT_W-1:0]        entry_count;
    logic [CAP_W-1:0]        nominal_capacity;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cat_req_if req_ch();
  cat_rsp_if rsp_ch();
  cat_cfg_if cfg_ch();

  compacting_array_table_top #(.MAX_ENTRIES(TABLE_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the list, count and capacity
  logic signed [VAL_W-1:0] tbl_entries [TABLE_DEPTH];
  int unsigned             tbl_count;
  int unsigned             tbl_cap;

  table_result_t pending_results[$];

  int unsigned mismatches = 0;
  int unsigned ops_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned req_gap_max = 0;
  int unsigned rsp_stall_max = 0;
  int unsigned cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("[%0t] error: %s", $time, what);
  endtask

  function automatic int unsigned draw_wait(int unsigned max_wait);
    if (max_wait == 0 || $urandom_range(0, 3) == 0)
      return 0;
    return $urandom_range(0, max_wait);
  endfunction

  // Applies one op to the shadow list and returns what the block must report.
  function automatic table_result_t apply_table_op(logic [OP_W-1:0] op,
                                                   logic signed [VAL_W-1:0] val,
                                                   logic [IDX_W-1:0] idx);
    table_result_t res;
    int unsigned   i;
    bit            hit;
    res.status      = ST_OK;
    res.read_value  = '0;
    res.found_index = '0;
    hit = 1'b0;
    case (op)
      OP_APPEND: begin
        if (tbl_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (tbl_cap == tbl_count)
            tbl_cap = (tbl_cap * 2 > int'(CAP_LIMIT)) ? int'(CAP_LIMIT) : tbl_cap * 2;
          tbl_entries[tbl_count] = val;
          tbl_count++;
        end
      end
      OP_REMOVE: begin
        if (idx >= tbl_count) begin
          res.status = ST_RANGE;
        end else begin
          for (i = idx; i + 1 < tbl_count; i++)
            tbl_entries[i] = tbl_entries[i + 1];
          tbl_count--;
          if (tbl_cap / 2 > tbl_count)
            tbl_cap = tbl_cap / 2;
        end
      end
      OP_READ: begin
        if (idx >= tbl_count)
          res.status = ST_RANGE;
        else
          res.read_value = tbl_entries[idx];
      end
      default: begin
        // find
        for (i = 0; i < tbl_count && !hit; i++) begin
          if (tbl_entries[i] == val) begin
            res.found_index = IDX_W'(i);
            hit = 1'b1;
          end
        end
        if (!hit)
          res.status = ST_ABSENT;
      end
    endcase
    res.entry_count      = CNT_W'(tbl_count);
    res.nominal_capacity = CAP_W'(tbl_cap);
    return res;
  endfunction

  task automatic send_op(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val,
                         logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = draw_wait(req_gap_max);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= val;
    req_ch.index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(apply_table_op(op, val, idx));
    ops_sent++;
  endtask

  // Drops valid and holds the request side until every result is back.
  task automatic wait_until_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_initial_capacity(logic [CFG_W-1:0] cap_value);
    wait_until_drained();
    repeat (2) @(posedge clk);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.initial_capacity <= cap_value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tbl_count    = 0;
    tbl_cap      = (cap_value == 0) ? 1 : cap_value;
    cfg_writes++;
  endtask

  task automatic check_result();
    table_result_t want;
    results_checked++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: status %0d count %0d",
                                rsp_ch.status, rsp_ch.entry_count));
      return;
    end
    want = pending_results.pop_front();
    if (rsp_ch.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", rsp_ch.status, want.status));
    if (rsp_ch.read_value !== want.read_value)
      report_mismatch($sformatf("read_value %h, want %h", rsp_ch.read_value,
                                want.read_value));
    if (rsp_ch.found_index !== want.found_index)
      report_mismatch($sformatf("found_index %0d, want %0d", rsp_ch.found_index,
                                want.found_index));
    if (rsp_ch.entry_count !== want.entry_count)
      report_mismatch($sformatf("entry_count %0d, want %0d", rsp_ch.entry_count,
                                want.entry_count));
    if (rsp_ch.nominal_capacity !== want.nominal_capacity)
      report_mismatch($sformatf("nominal_capacity %0d, want %0d",
                                rsp_ch.nominal_capacity, want.nominal_capacity));
  endtask

  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(rsp_stall_max);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      check_result();
    end
  end

  // Small pool gives duplicates so find has to pick the first match.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 7) - 4;
      1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if (tbl_count > 0 && $urandom_range(0, 99) < 85)
      return IDX_W'($urandom_range(0, tbl_count - 1));
    if (tbl_count < TABLE_DEPTH && $urandom_range(0, 1) == 0)
      return IDX_W'(tbl_count);
    return IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
  endfunction

  function automatic void pick_random_op(int unsigned pa, int unsigned pr, int unsigned pd,
                                         output logic [OP_W-1:0] op,
                                         output logic signed [VAL_W-1:0] val,
                                         output logic [IDX_W-1:0] idx);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) begin
      op  = OP_W'($urandom_range(0, 3));
      val = $urandom();
      idx = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
      return;
    end
    if (roll < pa)
      op = OP_APPEND;
    else if (roll < pa + pr)
      op = OP_REMOVE;
    else if (roll < pa + pr + pd)
      op = OP_READ;
    else
      op = OP_FIND;
    idx = pick_index();
    if (op == OP_FIND && tbl_count > 0 && $urandom_range(0, 9) < 6)
      val = tbl_entries[$urandom_range(0, tbl_count - 1)];
    else
      val = pick_value();
  endfunction

  task automatic test_directed_ops();
    req_gap_max   = 3;
    rsp_stall_max = 3;
    // empty list straight out of reset
    send_op(OP_READ, '0, '0);
    send_op(OP_REMOVE, '0, '0);
    send_op(OP_FIND, '0, '0);
    // growth 1 -> 2 -> 4 -> 8
    send_op(OP_APPEND, 32'sh7FFF_FFFF, '0);
    send_op(OP_APPEND, 32'sh8000_0000, '0);
    send_op(OP_APPEND, '0, '0);
    send_op(OP_APPEND, -32'sd1, '0);
    send_op(OP_APPEND, '0, '1);
    send_op(OP_READ, '0, IDX_W'(0));
    send_op(OP_READ, '0, IDX_W'(1));
    send_op(OP_READ, '0, IDX_W'(4));
    send_op(OP_READ, '0, IDX_W'(5));
    send_op(OP_READ, '0, '1);
    send_op(OP_FIND, '0, '0);
    send_op(OP_FIND, -32'sd1, '0);
    send_op(OP_FIND, 32'sh8000_0000, '0);
    send_op(OP_FIND, 32'sd12345, '0);
    send_op(OP_REMOVE, '0, '1);
    send_op(OP_REMOVE, '0, IDX_W'(0));
    send_op(OP_READ, '0, IDX_W'(0));
    send_op(OP_REMOVE, '0, IDX_W'(3));
    send_op(OP_REMOVE, '0, IDX_W'(0));
    send_op(OP_FIND, '0, '0);
    send_op(OP_READ, '0, IDX_W'(1));
    wait_until_drained();
  endtask

  task automatic test_fill_to_full();
    int unsigned n;
    req_gap_max   = MAX_WAIT;
    rsp_stall_max = MAX_WAIT;
    // zero is taken as one, so capacity doubles all the way to the store size
    write_initial_capacity('0);
    for (n = 0; n <= TABLE_DEPTH; n++)
      send_op(OP_APPEND, pick_value(), IDX_W'(n));
    send_op(OP_READ, '0, IDX_W'(TABLE_DEPTH - 1));
    send_op(OP_FIND, tbl_entries[TABLE_DEPTH - 1], '0);
    send_op(OP_REMOVE, '0, '0);
    send_op(OP_APPEND, $urandom(), '0);
    send_op(OP_APPEND, $urandom(), '0);
    // capacity write drops every entry
    write_initial_capacity('1);
    send_op(OP_READ, '0, '0);
    send_op(OP_FIND, '0, '0);
    send_op(OP_APPEND, $urandom(), '0);
    send_op(OP_APPEND, $urandom(), '0);
  endtask

  task automatic run_random_phase(logic [CFG_W-1:0] cap_value, int unsigned n_ops,
                                  int unsigned pa, int unsigned pr, int unsigned pd,
                                  int unsigned gap_max, int unsigned stall_max);
    int unsigned             n;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] val;
    logic [IDX_W-1:0]        idx;
    write_initial_capacity(cap_value);
    req_gap_max   = gap_max;
    rsp_stall_max = stall_max;
    for (n = 0; n < n_ops; n++) begin
      if ($urandom_range(0, 79) == 0)
        wait_until_drained();
      pick_random_op(pa, pr, pd, op, val, idx);
      send_op(op, val, idx);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(CFG_W'(1), 260, 40, 20, 20, MAX_WAIT, MAX_WAIT);
    // append heavy, no idling: runs into the full store
    run_random_phase(CFG_W'(64), 240, 60, 10, 15, 0, 0);
    run_random_phase('1, 220, 35, 25, 20, MAX_WAIT, 0);
    run_random_phase(CFG_W'($urandom_range(2, 63)), 220, 30, 35, 15, 0, MAX_WAIT);
    run_random_phase(CFG_W'($urandom_range(0, 127)), 240, 45, 25, 15, MAX_WAIT, MAX_WAIT);
  endtask

  initial begin
    req_ch.valid            = 1'b0;
    req_ch.op               = OP_APPEND;
    req_ch.value            = '0;
    req_ch.index            = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.initial_capacity = '0;
    tbl_count    = 0;
    tbl_cap      = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_fill_to_full();
    test_random_traffic();

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d ops sent, %0d results compared, %0d capacity writes", ops_sent,
             results_checked, cfg_writes);
    $display("covered empty and full store, shifting removes, growth and shrink, stalls");
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
